### rtl/chrl_pkg.sv
package chrl_pkg;

    localparam int HASH_W  = 32;
    localparam int SHARD_W = 7;
    localparam int BYTE_W  = 8;
    localparam int ACT_W   = 11;
    localparam int OP_W    = 2;
    localparam int INDEX_W = 10;
    localparam int ENTRY_W = HASH_W + SHARD_W;

    localparam logic [HASH_W-1:0] MIX_MUL = 32'h5bd1e995;
    localparam int FOLD_SHIFT  = 15;
    localparam int FINAL_SHIFT = 13;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_BYTE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [HASH_W-1:0]  hash;
        logic [SHARD_W-1:0] shard;
    } t_entry;

endpackage

### rtl/chrl_ram.sv
module chrl_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/consistent_hash_ring_lookup.sv
// write or zero byte: never busy; key byte: multiply, then xor-shift
// lookup: multiply, xor-shift, then a scan of min(active_entries, RING_DEPTH) entries up
// to o_done at the first hit, or a wrap to entry 0; one ring entry read a cycle
// one request at a time: busy is high while a byte or a lookup is in flight
// results are strobed for one cycle on o_done; the receiver cannot stall
// synchronous active-low reset clears the running hash, active_entries and control
module consistent_hash_ring_lookup #(
    parameter int RING_DEPTH  = 1024,
    parameter int SHARD_LIMIT = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [chrl_pkg::OP_W-1:0]     i_op,
    input  logic [chrl_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [chrl_pkg::HASH_W-1:0]   i_entry_hash,
    input  logic [chrl_pkg::SHARD_W-1:0]  i_entry_shard,
    input  logic [chrl_pkg::BYTE_W-1:0]   i_key_byte,
    input  logic                          i_cfg_we,
    input  logic [chrl_pkg::ACT_W-1:0]    i_cfg_data,
    output logic                          o_done,
    output logic [chrl_pkg::SHARD_W-1:0]  o_owner_shard,
    output logic                          o_wrapped,
    output logic [chrl_pkg::HASH_W-1:0]   o_key_hash
);

    import chrl_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_KEY,
        S_SCAN,
        S_WRAP
    } t_state;

    t_state              r_state;
    logic [HASH_W-1:0]   r_hash;
    logic [HASH_W-1:0]   r_prod;
    logic [HASH_W-1:0]   r_key;
    logic [ACT_W-1:0]    r_active;
    logic [CW-1:0]       r_limit;
    logic [CW-1:0]       r_idx;
    logic                r_pend;
    logic                r_done;
    logic [SHARD_W-1:0]  r_shard;
    logic                r_wrapped;
    logic [HASH_W-1:0]   r_key_out;

    logic                accept;
    logic                wr_en;
    logic [HASH_W-1:0]   mul_in;
    logic [HASH_W-1:0]   prod_mix;
    logic [AW-1:0]       rd_addr;
    t_entry              wr_entry;
    t_entry              rd_entry;
    logic                hit;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // writes beyond the ring or with an out-of-range shard are dropped
    assign wr_en = accept && (t_op'(i_op) == OP_WRITE)
                   && (32'(i_entry_index) < 32'(RING_DEPTH))
                   && (32'(i_entry_shard) < 32'(SHARD_LIMIT));

    assign wr_entry.hash  = i_entry_hash;
    assign wr_entry.shard = i_entry_shard;

    // byte fold and final mix share the one multiplier
    assign mul_in = (t_op'(i_op) == OP_BYTE) ? (r_hash ^ HASH_W'(i_key_byte))
                                             : (r_hash ^ (r_hash >> FINAL_SHIFT));
    assign prod_mix = r_prod ^ (r_prod >> FOLD_SHIFT);

    // past the last active entry the read falls back to entry 0 for the wrap case
    assign rd_addr = (r_idx < r_limit) ? r_idx[AW-1:0] : '0;
    assign hit     = r_pend && (rd_entry.hash >= r_key);

    chrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hash   <= '0;
            r_active <= '0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_prod <= mul_in * MIX_MUL;
                        if (t_op'(i_op) == OP_BYTE && i_key_byte != '0) begin
                            r_state <= S_FOLD;
                        end else if (t_op'(i_op) == OP_LOOKUP) begin
                            r_state <= S_KEY;
                        end
                    end
                end
                S_FOLD: begin
                    r_hash  <= prod_mix;
                    r_state <= S_IDLE;
                end
                S_KEY: begin
                    r_key  <= prod_mix;
                    r_hash <= '0;
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    if (32'(r_active) > 32'(RING_DEPTH)) begin
                        r_limit <= CW'(RING_DEPTH);
                    end else begin
                        r_limit <= CW'(r_active);
                    end
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (hit) begin
                        r_shard   <= rd_entry.shard;
                        r_wrapped <= 1'b0;
                        r_key_out <= r_key;
                        r_done    <= 1'b1;
                        r_pend    <= 1'b0;
                        r_state   <= S_IDLE;
                    end else if (r_idx >= r_limit) begin
                        r_pend  <= 1'b0;
                        r_state <= S_WRAP;
                    end else begin
                        r_idx  <= CW'(r_idx + 1'b1);
                        r_pend <= 1'b1;
                    end
                end
                S_WRAP: begin
                    r_shard   <= rd_entry.shard;
                    r_wrapped <= 1'b1;
                    r_key_out <= r_key;
                    r_done    <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_owner_shard = r_shard;
    assign o_wrapped     = r_wrapped;
    assign o_key_hash    = r_key_out;

    a_done_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_SCAN || $past(r_state) == S_WRAP))
        else $error("result strobe without a finished search");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while still busy");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_limit))
        else $error("scan pointer ran past the active entries");

    a_hash_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KEY) |=> (r_hash == '0))
        else $error("running hash not cleared after lookup");

    a_lookup_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_op'(i_op) == OP_LOOKUP) |=> (r_state == S_KEY))
        else $error("lookup request did not enter the final mix");

endmodule

### verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import chrl_pkg::*;

    localparam int RING_DEPTH     = 1024;
    localparam int LOADED_ENTRIES = 32;

    typedef struct {
        t_op                op;
        logic [INDEX_W-1:0] index;
        logic [HASH_W-1:0]  hash;
        logic [SHARD_W-1:0] shard;
        logic [BYTE_W-1:0]  key_byte;
    } t_request;

    typedef struct {
        logic [SHARD_W-1:0] owner_shard;
        logic               wrapped;
        logic [HASH_W-1:0]  key_hash;
    } t_route;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    i_op = '0;
    logic [INDEX_W-1:0] i_entry_index = '0;
    logic [HASH_W-1:0]  i_entry_hash = '0;
    logic [SHARD_W-1:0] i_entry_shard = '0;
    logic [BYTE_W-1:0]  i_key_byte = '0;
    logic               i_cfg_we = 1'b0;
    logic [ACT_W-1:0]   i_cfg_data = '0;
    logic               o_done;
    logic [SHARD_W-1:0] o_owner_shard;
    logic               o_wrapped;
    logic [HASH_W-1:0]  o_key_hash;

    // shadow of the block state
    logic [HASH_W-1:0]  ring_hash_mem [RING_DEPTH];
    logic [SHARD_W-1:0] ring_shard_mem [RING_DEPTH];
    logic [HASH_W-1:0]  key_accum = '0;
    logic [ACT_W-1:0]   active_count = '0;

    t_request pending_requests[$];
    t_route   predicted_routes[$];

    int  error_count = 0;
    int  accepted_count = 0;
    int  idle_left = 0;
    bit  took = 1'b0;

    int active_plan[12] = '{0, 1, 2, 3, 5, 7, 16, 64, 200, 1024, 2047, 1023};

    consistent_hash_ring_lookup i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_entry_hash  (i_entry_hash),
        .i_entry_shard (i_entry_shard),
        .i_key_byte    (i_key_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_owner_shard (o_owner_shard),
        .o_wrapped     (o_wrapped),
        .o_key_hash    (o_key_hash)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("consistent_hash_ring_lookup: mismatch");
        $finish;
    end

    function automatic logic [HASH_W-1:0] fold_key_byte(logic [HASH_W-1:0] h,
                                                        logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] t;
        t = (h ^ {24'b0, b}) * MIX_MUL;
        return t ^ (t >> FOLD_SHIFT);
    endfunction

    function automatic logic [HASH_W-1:0] finish_key_hash(logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = (h ^ (h >> FINAL_SHIFT)) * MIX_MUL;
        return t ^ (t >> FOLD_SHIFT);
    endfunction

    task automatic route_request(input t_request r);
        t_route res;
        int     n;
        bit     found;
        int     pick;
        case (r.op)
            OP_WRITE: begin
                ring_hash_mem[r.index]  = r.hash;
                ring_shard_mem[r.index] = r.shard;
            end
            OP_BYTE: begin
                if (r.key_byte != 0)
                    key_accum = fold_key_byte(key_accum, r.key_byte);
            end
            OP_LOOKUP: begin
                res.key_hash = finish_key_hash(key_accum);
                n = (active_count > RING_DEPTH) ? RING_DEPTH : int'(active_count);
                found = 1'b0;
                pick = 0;
                for (int i = 0; i < n; i++) begin
                    if (!found && ring_hash_mem[i] >= res.key_hash) begin
                        found = 1'b1;
                        pick = i;
                    end
                end
                res.owner_shard = ring_shard_mem[pick];
                res.wrapped     = !found;
                predicted_routes.push_back(res);
                key_accum = '0;
            end
            default: ;
        endcase
    endtask

    // acceptance, prediction and gap choice
    always @(posedge i_clk) begin
        int r;
        if (i_cfg_we)
            active_count = i_cfg_data;
        if (i_rst_n && start && !busy) begin
            route_request('{op: t_op'(i_op), index: i_entry_index, hash: i_entry_hash,
                            shard: i_entry_shard, key_byte: i_key_byte});
            accepted_count++;
            took = 1'b1;
            r = $urandom_range(0, 99);
            if ((accepted_count % 300) < 80 || r < 60)
                idle_left = 0;
            else if (r < 92)
                idle_left = $urandom_range(1, 3);
            else
                idle_left = $urandom_range(10, 40);
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_request q;
        if (took || !start) begin
            took = 1'b0;
            if (idle_left > 0) begin
                start <= 1'b0;
                idle_left--;
            end else if (pending_requests.size() > 0) begin
                q = pending_requests.pop_front();
                i_op          <= q.op;
                i_entry_index <= q.index;
                i_entry_hash  <= q.hash;
                i_entry_shard <= q.shard;
                i_key_byte    <= q.key_byte;
                start         <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_route exp_route;
        if (o_done) begin
            if (predicted_routes.size() == 0) begin
                $display("%0t unexpected result owner_shard %0d wrapped %0d key_hash %h",
                         $time, o_owner_shard, o_wrapped, o_key_hash);
                error_count++;
            end else begin
                exp_route = predicted_routes.pop_front();
                if (o_owner_shard !== exp_route.owner_shard) begin
                    $display("%0t owner_shard expected %0d got %0d",
                             $time, exp_route.owner_shard, o_owner_shard);
                    error_count++;
                end
                if (o_wrapped !== exp_route.wrapped) begin
                    $display("%0t wrapped expected %0d got %0d",
                             $time, exp_route.wrapped, o_wrapped);
                    error_count++;
                end
                if (o_key_hash !== exp_route.key_hash) begin
                    $display("%0t key_hash expected %h got %h",
                             $time, exp_route.key_hash, o_key_hash);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_request(input t_op op, input logic [INDEX_W-1:0] idx,
                                 input logic [HASH_W-1:0] h, input logic [SHARD_W-1:0] sh,
                                 input logic [BYTE_W-1:0] b);
        pending_requests.push_back('{op: op, index: idx, hash: h, shard: sh, key_byte: b});
    endtask

    task automatic queue_write(input int idx, input logic [HASH_W-1:0] h,
                               input logic [SHARD_W-1:0] sh);
        queue_request(OP_WRITE, idx[INDEX_W-1:0], h, sh, BYTE_W'($urandom));
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        queue_request(OP_BYTE, INDEX_W'($urandom), $urandom, SHARD_W'($urandom), b);
    endtask

    task automatic queue_lookup();
        queue_request(OP_LOOKUP, INDEX_W'($urandom), $urandom, SHARD_W'($urandom),
                      BYTE_W'($urandom));
    endtask

    // ascending hashes for entries 0..m-1 spread over the full range
    task automatic queue_spread_ring(input int m);
        longint unsigned span;
        longint unsigned r;
        for (int i = 0; i < m; i++) begin
            span = 64'h1_0000_0000 / m;
            r = $urandom;
            queue_write(i, 32'(longint'(i) * span + r % span), SHARD_W'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || start || predicted_routes.size() != 0)
            @(posedge i_clk);
        // a key byte may still be in flight
        repeat (8) @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic write_active(input int v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[ACT_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= ACT_W'($urandom);
    endtask

    // guard names the entry that tops the range and must keep its hash, or -1
    task automatic run_traffic(input int budget, input int guard);
        int counted;
        int sel;
        int len;
        int idx;
        logic [BYTE_W-1:0] b;
        counted = 0;
        while (counted < budget) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(0, 5);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        queue_byte(8'h00);
                    end else begin
                        b = BYTE_W'($urandom_range(1, 255));
                        queue_byte(b);
                        counted++;
                    end
                end
                queue_lookup();
                counted++;
            end else if (sel < 82) begin
                idx = $urandom_range(0, RING_DEPTH - 1);
                if (idx == guard)
                    idx = guard - 1;
                queue_write(idx, $urandom, SHARD_W'($urandom));
                counted++;
            end else if (sel < 88) begin
                queue_request(OP_NONE, INDEX_W'($urandom), $urandom, SHARD_W'($urandom),
                              BYTE_W'($urandom));
            end else if (sel < 95) begin
                // stray byte that spills into the next key
                b = BYTE_W'($urandom);
                queue_byte(b);
                if (b != 0)
                    counted++;
            end else begin
                queue_lookup();
                counted++;
            end
        end
    endtask

    initial begin
        logic [HASH_W-1:0] pair_hash;
        int m;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty ring right after reset, extreme bytes, ignored zero byte and op 3
        queue_write(RING_DEPTH - 1, 32'hFFFF_FFFF, 7'd127);
        queue_write(0, 32'h0000_0000, 7'd0);
        queue_lookup();
        queue_byte(8'hFF);
        queue_byte(8'h01);
        queue_byte(8'h00);
        queue_request(OP_NONE, '1, '1, '1, '1);
        queue_lookup();
        queue_byte(8'h80);
        queue_lookup();
        wait_idle();

        // hash equal to an entry, one below, and all below
        pair_hash = finish_key_hash(fold_key_byte(fold_key_byte('0, 8'h41), 8'h42));
        write_active(2);
        queue_write(0, pair_hash - 1, 7'd5);
        queue_write(1, pair_hash, 7'd9);
        queue_byte(8'h41);
        queue_byte(8'h42);
        queue_lookup();
        queue_write(0, pair_hash, 7'd3);
        queue_byte(8'h41);
        queue_byte(8'h42);
        queue_lookup();
        queue_write(0, pair_hash - 1, 7'd126);
        queue_write(1, pair_hash - 1, 7'd1);
        queue_byte(8'h41);
        queue_byte(8'h42);
        queue_lookup();
        queue_lookup();
        wait_idle();

        foreach (active_plan[p]) begin
            write_active(active_plan[p]);
            m = (active_plan[p] > RING_DEPTH) ? RING_DEPTH : active_plan[p];
            if (m > LOADED_ENTRIES) begin
                // only the first entries are loaded, the last of them holds the top hash
                queue_spread_ring(LOADED_ENTRIES);
                queue_write(LOADED_ENTRIES - 1, 32'hFFFF_FFFF, SHARD_W'($urandom));
                run_traffic(68, LOADED_ENTRIES - 1);
            end else begin
                queue_spread_ring(m);
                run_traffic(68, -1);
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("consistent_hash_ring_lookup: match");
        else
            $display("consistent_hash_ring_lookup: mismatch");
        $finish;
    end

endmodule
